@@ rtl/pfb_pkg.sv @@
// Shared command codes and controller/datapath handshake structs for the
// page framebuffer. No dependencies; used by pfb_ctrl, pfb_datapath and the top level.
package pfb_pkg;

    localparam int COORD_W = 8;
    localparam int PAGE_W  = 5;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_POINT = 2'd1;
    localparam logic [1:0] CMD_FILL  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    typedef struct packed {
        logic load;
        logic clr_write;
        logic fetch;
        logic modify;
        logic resp_load;
    } pfb_cmd_t;

    typedef struct packed {
        logic empty;
        logic clr_last;
        logic walk_last;
        logic out_free;
    } pfb_sts_t;

endpackage

@@ rtl/pfb_datapath.sv @@
// Frame store memory, rectangle walker, clear counter and result register.
// Depends on pfb_pkg; driven by pfb_ctrl through pfb_cmd_t.
module pfb_datapath
    import pfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  pfb_cmd_t           cmd,
    output pfb_sts_t           sts,
    input  logic [1:0]         cmd_in,
    input  logic [COORD_W-1:0] x_a,
    input  logic [COORD_W-1:0] y_a,
    input  logic [COORD_W-1:0] x_b,
    input  logic [COORD_W-1:0] y_b,
    input  logic               pixel_on,
    input  logic [2:0]         read_page,
    input  logic [6:0]         read_column,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         read_byte,
    output logic               point_ignored
);

    localparam int PAGE_COUNT = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = PAGE_COUNT * PANEL_WIDTH;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam logic [8:0] WIDTH9 = 9'(PANEL_WIDTH);
    localparam logic [8:0] HEIGHT9 = 9'(PANEL_HEIGHT);
    localparam logic [5:0] PAGES6 = 6'(PAGE_COUNT);
    localparam logic [COORD_W-1:0] X_MAX = COORD_W'(PANEL_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(PANEL_HEIGHT - 1);

    logic [7:0] frame_store_reg [STORE_SIZE];
    logic [7:0] rdata_reg;

    logic [COORD_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg, col_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               on_reg, ignored_reg, read_ok_reg;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_ignored_reg;

    logic [COORD_W-1:0] x0_next, x1_next, y0_next, y1_next;
    logic               point_off, is_point;
    logic [ADDR_W-1:0]  walk_addr;
    logic [2:0]         bit_lo, bit_hi;
    logic [7:0]         mask, modified;

    // Order the corners per axis and clip the far corner to the panel; a point is taken as given
    always_comb
    begin
        is_point  = (cmd_in == CMD_POINT);
        point_off = ({1'b0, x_a} >= WIDTH9) || ({1'b0, y_a} >= HEIGHT9);
        if (is_point)
        begin
            x0_next = x_a;
            x1_next = x_a;
            y0_next = y_a;
            y1_next = y_a;
        end
        else
        begin
            x0_next = (x_a < x_b) ? x_a : x_b;
            x1_next = (x_a < x_b) ? x_b : x_a;
            y0_next = (y_a < y_b) ? y_a : y_b;
            y1_next = (y_a < y_b) ? y_b : y_a;
            if (x1_next > X_MAX)
                x1_next = X_MAX;
            if (y1_next > Y_MAX)
                y1_next = Y_MAX;
        end
    end

    always_comb
    begin
        sts.empty = (is_point && point_off) || (x0_next > x1_next) || (y0_next > y1_next);
        walk_addr = ADDR_W'(32'(page_reg) * PANEL_WIDTH + 32'(col_reg));
        bit_lo = (page_reg == y0_reg[7:3]) ? y0_reg[2:0] : 3'd0;
        bit_hi = (page_reg == y1_reg[7:3]) ? y1_reg[2:0] : 3'd7;
        for (int b = 0; b < 8; b++)
            mask[b] = (3'(b) >= bit_lo) && (3'(b) <= bit_hi);
        modified = on_reg ? (rdata_reg | mask) : (rdata_reg & ~mask);
        sts.clr_last  = (clr_addr_reg == ADDR_W'(STORE_SIZE - 1));
        sts.walk_last = (col_reg == x1_reg) && (page_reg == y1_reg[7:3]);
        sts.out_free  = !out_valid_reg || m_tready;
        clr_addr_next = sts.clr_last ? '0 : clr_addr_reg + 1'b1;
    end

    // Command registers and walker position
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x0_reg      <= x0_next;
            x1_reg      <= x1_next;
            y0_reg      <= y0_next;
            y1_reg      <= y1_next;
            on_reg      <= pixel_on;
            ignored_reg <= is_point && point_off;
            read_ok_reg <= (cmd_in == CMD_READ) && ({3'b0, read_page} < PAGES6)
                           && ({2'b0, read_column} < WIDTH9);
            if (cmd_in == CMD_READ)
            begin
                page_reg <= PAGE_W'(read_page);
                col_reg  <= COORD_W'(read_column);
            end
            else
            begin
                page_reg <= y0_next[7:3];
                col_reg  <= x0_next;
            end
        end
        else if (cmd.modify)
        begin
            // Advance to the next column, wrap to the next page at the rectangle's right column (x1)
            if (col_reg == x1_reg)
            begin
                col_reg  <= x0_reg;
                page_reg <= page_reg + 1'b1;
            end
            else
                col_reg <= col_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_write)
            frame_store_reg[clr_addr_reg] <= 8'h00;
        else if (cmd.modify)
            frame_store_reg[walk_addr] <= modified;
        if (cmd.fetch)
            rdata_reg <= frame_store_reg[walk_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
                clr_addr_reg <= clr_addr_next;
            if (cmd.resp_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            out_byte_reg    <= read_ok_reg ? rdata_reg : 8'h00;
            out_ignored_reg <= ignored_reg;
        end
    end

    assign m_tvalid      = out_valid_reg;
    assign read_byte     = out_byte_reg;
    assign point_ignored = out_ignored_reg;

endmodule

@@ rtl/pfb_ctrl.sv @@
// Command sequencer for the page framebuffer: reset sweep, clear, byte
// read-modify-write walk and result hand-off. Depends on pfb_pkg.
module pfb_ctrl
    import pfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] cmd_in,
    output pfb_cmd_t   cmd,
    input  pfb_sts_t   sts
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_MODIFY = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] kind_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (cmd_in)
                        CMD_CLEAR: state_next = S_CLEAR;
                        CMD_READ:  state_next = S_FETCH;
                        default:   state_next = sts.empty ? S_RESP : S_FETCH;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_last)
                    state_next = S_RESP;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = (kind_reg == CMD_READ) ? S_RESP : S_MODIFY;
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = sts.walk_last ? S_RESP : S_FETCH;
            end
            S_RESP:
            begin
                // Hold the result until the output register frees up
                if (sts.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            kind_reg <= cmd_in;
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clr_write, cmd.fetch, cmd.modify, cmd.resp_load}))
        else $error("pfb_ctrl: more than one datapath command at once");

    a_modify_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.modify |-> $past(cmd.fetch))
        else $error("pfb_ctrl: modify without a preceding fetch");

    a_resp_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_load |-> sts.out_free)
        else $error("pfb_ctrl: result loaded over a pending word");

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg != S_IDLE))
        else $error("pfb_ctrl: accepted command did not start");

endmodule

@@ rtl/page_framebuffer_draw_fill_top.sv @@
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser = cmd, s_tdata = coords, pixel_on, read address
// m_        out  m_tvalid/m_tready  m_tdata = read_byte, m_tuser = point_ignored
//
// After reset the frame store is swept to zero with s_tready low.
// Point draw: accept, fetch, modify, result; read: accept, fetch, result; off-panel point:
// accept, result. Fill: one memory read and one write per byte touched, plus accept and result;
// clear: one write per store byte, plus accept and result; the frame store is single-port.
// A new word is taken while the previous result still waits in the output register.
module page_framebuffer_draw_fill_top
    import pfb_pkg::*;
#(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] x_a, [15:8] y_a, [23:16] x_b, [31:24] y_b, [32] pixel_on,
    // [35:33] read_page, [42:36] read_column, [47:43] zero
    input  logic [47:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_byte
    output logic [7:0]  m_tdata,
    // [0] point_ignored
    output logic        m_tuser
);

    pfb_cmd_t cmd;
    pfb_sts_t sts;

    pfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd_in   (s_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

    pfb_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cmd_in        (s_tuser),
        .x_a           (s_tdata[7:0]),
        .y_a           (s_tdata[15:8]),
        .x_b           (s_tdata[23:16]),
        .y_b           (s_tdata[31:24]),
        .pixel_on      (s_tdata[32]),
        .read_page     (s_tdata[35:33]),
        .read_column   (s_tdata[42:36]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .read_byte     (m_tdata),
        .point_ignored (m_tuser)
    );

endmodule
